### hw/rtl/checksummed_response_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checksummed response frame receiver.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CRFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CRFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CRFR_ASSERT_IMPL(lbl, ante, cons)
`define CRFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/crfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfr_pkg
// Types, codes and constants shared by the response frame receiver.
// ----------------------------------------------------------------------------
package crfr_pkg;

  localparam int unsigned CRFR_MAX_FRAME = 32;
  localparam int unsigned CRFR_CFG_W     = 16;

  localparam logic [7:0]  CRFR_START_RST   = 8'd2;
  localparam logic [15:0] CRFR_TIMEOUT_RST = 16'd1000;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } crfr_op_e;

  typedef enum logic [0:0] {
    CFG_START_BYTE = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } crfr_cfg_e;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CMD   = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_TIMEOUT   = 3'd6,
    ST_OVERFLOW  = 3'd7
  } crfr_status_e;

  typedef struct packed {
    logic         arm;
    logic         go_idle;
    logic         take_byte;
    logic         tick;
    logic         emit_start;
    logic         emit_step;
    logic         load_out;
    logic         from_ram;
    crfr_status_e out_status;
  } crfr_cmd_t;

  typedef struct packed {
    logic idx_start;
    logic idx_len;
    logic idx_cmd;
    logic in_payload;
    logic start_ok;
    logic len_zero;
    logic len_big;
    logic cmd_ok;
    logic sum_ok;
    logic frame_empty;
    logic tick_expired;
    logic emit_last;
  } crfr_stat_t;

endpackage

### hw/rtl/crfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 29,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/crfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfr_dp
// Datapath: configuration, frame counters, checksum, payload RAM and the
// output register.
// ----------------------------------------------------------------------------
module crfr_dp import crfr_pkg::*; #(
  parameter int unsigned MAX_FRAME = CRFR_MAX_FRAME
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CRFR_CFG_W-1:0] cfg_data_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            cmd_byte_i,
  input  crfr_cmd_t             cmd_i,
  output crfr_stat_t            stat_o,
  output crfr_status_e          out_status_o,
  output logic [7:0]            out_byte_o,
  output logic [4:0]            out_index_o,
  output logic [4:0]            out_length_o,
  output logic                  out_last_o
);

  localparam int unsigned CAP = MAX_FRAME - 3;
  localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned EW  = $clog2(CAP + 1);
  localparam int unsigned BIW = $clog2(MAX_FRAME + 1);

  logic [7:0]     start_byte_q;
  logic [15:0]    timeout_q;
  logic [BIW-1:0] byte_index_q, byte_index_d;
  logic [7:0]     want_cmd_q, want_cmd_d;
  logic [7:0]     frame_len_q, frame_len_d;
  logic [7:0]     running_sum_q, running_sum_d;
  logic [15:0]    tick_count_q, tick_count_d;
  logic [EW-1:0]  emit_idx_q, emit_idx_d;

  logic [7:0]     sum_new;
  logic [15:0]    tick_inc;
  logic [7:0]     ram_rdata;
  logic           ram_we;

  crfr_status_e   out_status_q;
  logic [7:0]     out_byte_q;
  logic [4:0]     out_index_q;
  logic [4:0]     out_length_q;
  logic           out_last_q;

  assign sum_new  = running_sum_q + byte_i;
  assign tick_inc = (tick_count_q == 16'hFFFF) ? tick_count_q : tick_count_q + 16'd1;

  assign stat_o.idx_start    = (byte_index_q == '0);
  assign stat_o.idx_len      = (byte_index_q == BIW'(1));
  assign stat_o.idx_cmd      = (byte_index_q == BIW'(2));
  assign stat_o.in_payload   = (byte_index_q >= BIW'(3)) &&
                               (10'(byte_index_q) < 10'(frame_len_q) + 10'd2);
  assign stat_o.start_ok     = (byte_i == start_byte_q);
  assign stat_o.len_zero     = (byte_i == 8'd0);
  assign stat_o.len_big      = ({1'b0, byte_i} > 9'(CAP + 1));
  assign stat_o.cmd_ok       = (byte_i == want_cmd_q);
  assign stat_o.sum_ok       = (sum_new == 8'd0);
  assign stat_o.frame_empty  = (frame_len_q == 8'd1);
  assign stat_o.tick_expired = (tick_inc >= timeout_q);
  assign stat_o.emit_last    = (9'(emit_idx_q) + 9'd1 == 9'(frame_len_q) - 9'd1);

  always_comb begin
    byte_index_d  = byte_index_q;
    want_cmd_d    = want_cmd_q;
    frame_len_d   = frame_len_q;
    running_sum_d = running_sum_q;
    tick_count_d  = tick_count_q;
    emit_idx_d    = emit_idx_q;
    if (cmd_i.go_idle) begin
      byte_index_d  = '0;
      running_sum_d = '0;
      tick_count_d  = '0;
    end
    if (cmd_i.arm) begin
      want_cmd_d = cmd_byte_i;
    end
    if (cmd_i.take_byte) begin
      running_sum_d = sum_new;
      byte_index_d  = byte_index_q + BIW'(1);
      if (stat_o.idx_len) begin
        frame_len_d = byte_i;
      end
    end
    if (cmd_i.tick) begin
      tick_count_d = tick_inc;
    end
    if (cmd_i.emit_start) begin
      emit_idx_d = '0;
    end else if (cmd_i.emit_step) begin
      emit_idx_d = emit_idx_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q  <= CRFR_START_RST;
      timeout_q     <= CRFR_TIMEOUT_RST;
      byte_index_q  <= '0;
      want_cmd_q    <= '0;
      frame_len_q   <= '0;
      running_sum_q <= '0;
      tick_count_q  <= '0;
      emit_idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (crfr_cfg_e'(cfg_idx_i))
          CFG_START_BYTE: start_byte_q <= cfg_data_i[7:0];
          CFG_TIMEOUT:    timeout_q    <= cfg_data_i[15:0];
          default:        ;
        endcase
      end
      byte_index_q  <= byte_index_d;
      want_cmd_q    <= want_cmd_d;
      frame_len_q   <= frame_len_d;
      running_sum_q <= running_sum_d;
      tick_count_q  <= tick_count_d;
      emit_idx_q    <= emit_idx_d;
    end
  end

  // The read address follows the next emit index, so the registered read
  // data always holds the entry at the current emit index.
  assign ram_we = cmd_i.take_byte && stat_o.in_payload;

  crfr_ram #(
    .WIDTH (8),
    .DEPTH (CAP)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(byte_index_q - BIW'(3))),
    .wdata_i (byte_i),
    .raddr_i (AW'(emit_idx_d)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.from_ram) begin
        out_status_q <= ST_DATA;
        out_byte_q   <= ram_rdata;
        out_index_q  <= 5'(emit_idx_q);
        out_length_q <= 5'(frame_len_q - 8'd1);
        out_last_q   <= stat_o.emit_last;
      end else begin
        out_status_q <= cmd_i.out_status;
        out_byte_q   <= '0;
        out_index_q  <= '0;
        out_length_q <= '0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_status_o = out_status_q;
  assign out_byte_o   = out_byte_q;
  assign out_index_o  = out_index_q;
  assign out_length_o = out_length_q;
  assign out_last_o   = out_last_q;

endmodule

### hw/rtl/crfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfr_ctrl
// Controller: frame state machine, input and output handshakes.
// ----------------------------------------------------------------------------
module crfr_ctrl import crfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  crfr_stat_t stat_i,
  output crfr_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ARMED = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e       state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;
  logic         accept;
  logic         fail;
  crfr_status_e fail_code;
  crfr_op_e     op;

  assign op         = crfr_op_e'(op_i);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = ((state_q == S_IDLE) || (state_q == S_ARMED)) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    fail      = 1'b0;
    fail_code = ST_BAD_START;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op == OP_START)) begin
          cmd_o.arm     = 1'b1;
          cmd_o.go_idle = 1'b1;
          state_d       = S_ARMED;
        end
      end
      S_ARMED: begin
        if (accept) begin
          case (op)
            OP_START: begin
              cmd_o.arm     = 1'b1;
              cmd_o.go_idle = 1'b1;
            end
            OP_BYTE: begin
              if (stat_i.idx_start) begin
                fail           = !stat_i.start_ok;
                fail_code      = ST_BAD_START;
                cmd_o.take_byte = stat_i.start_ok;
              end else if (stat_i.idx_len) begin
                fail            = stat_i.len_zero || stat_i.len_big;
                fail_code       = stat_i.len_zero ? ST_BAD_LEN : ST_OVERFLOW;
                cmd_o.take_byte = !fail;
              end else if (stat_i.idx_cmd) begin
                fail            = !stat_i.cmd_ok;
                fail_code       = ST_BAD_CMD;
                cmd_o.take_byte = stat_i.cmd_ok;
              end else if (stat_i.in_payload) begin
                cmd_o.take_byte = 1'b1;
              end else if (!stat_i.sum_ok) begin
                fail      = 1'b1;
                fail_code = ST_CHECKSUM;
              end else begin
                // Checksum good: the frame closes and the payload is replayed, or an empty frame gives an empty status.
                cmd_o.go_idle = 1'b1;
                if (stat_i.frame_empty) begin
                  cmd_o.load_out   = 1'b1;
                  cmd_o.out_status = ST_EMPTY;
                  state_d          = S_IDLE;
                end else begin
                  cmd_o.emit_start = 1'b1;
                  state_d          = S_EMIT;
                end
              end
            end
            OP_TICK: begin
              cmd_o.tick = 1'b1;
              fail       = stat_i.tick_expired;
              fail_code  = ST_TIMEOUT;
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.from_ram  = 1'b1;
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fail) begin
      cmd_o.go_idle    = 1'b1;
      cmd_o.load_out   = 1'b1;
      cmd_o.out_status = fail_code;
      state_d          = S_IDLE;
    end
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/checksummed_response_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_response_frame_receiver
// Parses one start/length/command/data/checksum response frame and streams
// out its payload bytes or a single status.
// ----------------------------------------------------------------------------
// A start, tick or byte item is taken whenever the receiver is idle or armed
// and the output register is empty or being drained. After a good checksum
// the payload is replayed from the payload RAM at one byte per cycle while
// the output is free: LEN-1 results, the first loaded into the output
// register from the emit state, because the read of the first entry is
// started as the checksum item is taken; no input item is taken during the
// replay. The single read port of the payload RAM sets that rate. Errors,
// timeouts and empty frames give one result in the cycle after the item.
`include "checksummed_response_frame_receiver_macros.svh"

module checksummed_response_frame_receiver import crfr_pkg::*; #(
  parameter int unsigned MAX_FRAME = CRFR_MAX_FRAME
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CRFR_CFG_W-1:0] cfg_data_i,
  // Input item stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // byte_value[7:0], expected_cmd[15:8]
  input  logic [1:0]            s_axis_tuser,  // operation[1:0]
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // data_byte[7:0], data_index[12:8],
                                               // data_length[17:13], zero[23:18]
  output logic [2:0]            m_axis_tuser,  // status[2:0]
  output logic                  m_axis_tlast
);

  crfr_cmd_t    cmd;
  crfr_stat_t   stat;
  crfr_status_e out_status;
  logic [7:0]   out_byte;
  logic [4:0]   out_index;
  logic [4:0]   out_length;

  crfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crfr_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .byte_i       (s_axis_tdata[7:0]),
    .cmd_byte_i   (s_axis_tdata[15:8]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status_o (out_status),
    .out_byte_o   (out_byte),
    .out_index_o  (out_index),
    .out_length_o (out_length),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_length, out_index, out_byte};
  assign m_axis_tuser = out_status;

  // A held result must never be overwritten by a new one.
  `CRFR_ASSERT_IMPL(a_no_overwrite, cmd.load_out && m_axis_tvalid, m_axis_tready)
  // No item is taken while the payload is being replayed.
  `CRFR_ASSERT_IMPL(a_no_take_in_replay, cmd.emit_step, !s_axis_tready)
  // Every status other than a data byte is the only result of its item.
  `CRFR_ASSERT_IMPL(a_status_is_last, m_axis_tvalid && (m_axis_tuser != ST_DATA), m_axis_tlast)
  // The input stays closed in the first cycle of a replay.
  `CRFR_ASSERT_NEXT(a_replay_starts, cmd.emit_start, !s_axis_tready)

endmodule

### tb/sv/checksummed_response_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_response_frame_receiver_test
// Self-checking bench for the response frame receiver. A short table of
// directed items is followed by random frames, some of them corrupted, under
// several register settings and idle patterns on both streams. Every result
// is compared with the output of a behavioural frame parser kept in step,
// or with the status that the directed table gives for its row.
module checksummed_response_frame_receiver_test;
  import crfr_pkg::*;

  localparam int unsigned PAYLOAD_CAP   = CRFR_MAX_FRAME - 3;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          PHASE_ITEMS   = 25;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] cmd;
  } frame_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic [4:0] index;
    logic [4:0] length;
    logic       last;
  } frame_result_t;

  typedef struct {
    frame_item_t  it;
    bit           typed;
    crfr_status_e status;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CRFR_CFG_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  checksummed_response_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Behavioural copy of the parser state and registers.
  logic [7:0]  cfg_start;
  logic [15:0] cfg_timeout;
  bit          rx_armed;
  int unsigned rx_pos;
  logic [7:0]  rx_cmd;
  logic [7:0]  rx_len;
  logic [7:0]  rx_sum;
  logic [15:0] rx_ticks;
  logic [7:0]  rx_payload [PAYLOAD_CAP];

  frame_result_t step_results [$];
  frame_result_t results_due [$];
  directed_row_t directed_rows [$];

  int mismatches = 0;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  function automatic void drop_frame();
    rx_armed = 1'b0;
    rx_pos   = 0;
    rx_len   = 8'd0;
    rx_sum   = 8'd0;
    rx_ticks = 16'd0;
  endfunction

  function automatic void abort_frame(crfr_status_e status);
    drop_frame();
    step_results.push_back(frame_result_t'{status, 8'd0, 5'd0, 5'd0, 1'b1});
  endfunction

  // Works out the results that one accepted item causes.
  function automatic void step_receiver(frame_item_t it);
    int unsigned n;
    step_results.delete();
    case (it.op)
      OP_START: begin
        drop_frame();
        rx_armed = 1'b1;
        rx_cmd   = it.cmd;
      end
      OP_TICK: if (rx_armed) begin
        if (rx_ticks != 16'hFFFF) rx_ticks++;
        if (rx_ticks >= cfg_timeout) abort_frame(ST_TIMEOUT);
      end
      OP_BYTE: if (rx_armed) begin
        rx_sum = rx_sum + it.rx_byte;
        if (rx_pos == 0) begin
          if (it.rx_byte != cfg_start) abort_frame(ST_BAD_START);
          else rx_pos = 1;
        end else if (rx_pos == 1) begin
          if (it.rx_byte == 8'd0) abort_frame(ST_BAD_LEN);
          else if (it.rx_byte - 1 > PAYLOAD_CAP) abort_frame(ST_OVERFLOW);
          else begin
            rx_len = it.rx_byte;
            rx_pos = 2;
          end
        end else if (rx_pos == 2) begin
          if (it.rx_byte != rx_cmd) abort_frame(ST_BAD_CMD);
          else rx_pos = 3;
        end else if (rx_pos < rx_len + 2) begin
          rx_payload[rx_pos - 3] = it.rx_byte;
          rx_pos++;
        end else if (rx_sum != 8'd0) begin
          abort_frame(ST_CHECKSUM);
        end else begin
          // Good checksum: the buffered payload goes out in order, or an empty frame gives an empty status.
          n = rx_len - 1;
          drop_frame();
          if (n == 0) begin
            step_results.push_back(frame_result_t'{ST_EMPTY, 8'd0, 5'd0, 5'd0, 1'b1});
          end else begin
            for (int unsigned i = 0; i < n; i++)
              step_results.push_back(frame_result_t'{ST_DATA, rx_payload[i], 5'(i),
                                                     5'(n), 1'(i + 1 == n)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic directed_row_t dir_row(logic [1:0] op, logic [7:0] b, logic [7:0] c,
                                            bit typed = 1'b0,
                                            crfr_status_e status = ST_DATA);
    directed_row_t r;
    r.it     = frame_item_t'{op, b, c};
    r.typed  = typed;
    r.status = status;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Sends one item at the falling edge and updates the prediction once it is taken.
  task automatic send_item(frame_item_t it, bit typed = 1'b0,
                           crfr_status_e status = ST_DATA);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.cmd, it.rx_byte};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    step_receiver(it);
    if (typed) results_due.push_back(frame_result_t'{status, 8'd0, 5'd0, 5'd0, 1'b1});
    else foreach (step_results[i]) results_due.push_back(step_results[i]);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(crfr_cfg_e which, logic [CRFR_CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_START_BYTE) cfg_start = value[7:0];
    else cfg_timeout = value;
    @(negedge clk_i);
  endtask

  // A well-formed frame with random content, sometimes corrupted or cut short,
  // with ticks scattered through it and now and then a stray item ahead of it.
  task automatic send_random_frame(output int n_items);
    logic [7:0]  cmd;
    logic [7:0]  sum;
    logic [7:0]  frame_bytes [$];
    int          plen;
    int          k;
    n_items = 0;
    cmd  = 8'($urandom);
    plen = ($urandom_range(99) < 8) ? PAYLOAD_CAP : $urandom_range(6);
    frame_bytes = '{cfg_start, 8'(plen + 1), cmd};
    repeat (plen) frame_bytes.push_back(8'($urandom));
    sum = 8'd0;
    foreach (frame_bytes[i]) sum += frame_bytes[i];
    frame_bytes.push_back(8'(8'd0 - sum));
    if ($urandom_range(99) < 25) begin
      k = $urandom_range(frame_bytes.size() - 1);
      frame_bytes[k] ^= 8'($urandom_range(1, 255));
    end
    if ($urandom_range(99) < 8)
      repeat ($urandom_range(1, frame_bytes.size() - 1))
        frame_bytes.delete(frame_bytes.size() - 1);
    if ($urandom_range(99) < 10) begin
      send_item(frame_item_t'{2'($urandom), 8'($urandom), 8'($urandom)});
      n_items++;
    end
    send_item(frame_item_t'{OP_START, 8'($urandom), cmd});
    n_items++;
    foreach (frame_bytes[i]) begin
      if ($urandom_range(99) < 8) begin
        send_item(frame_item_t'{OP_TICK, 8'($urandom), 8'($urandom)});
        n_items++;
      end
      send_item(frame_item_t'{OP_BYTE, frame_bytes[i], 8'($urandom)});
      n_items++;
    end
  endtask

  task automatic run_random_phase(logic [7:0] start_value, logic [15:0] timeout_value,
                                  int src_pct, int sink_pct);
    int sent;
    int n;
    quiesce();
    write_register(CFG_START_BYTE, CRFR_CFG_W'(start_value));
    write_register(CFG_TIMEOUT, timeout_value);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      send_random_frame(n);
      sent += n;
    end
    // A wrong first byte leaves the receiver idle for the next register write.
    send_item(frame_item_t'{OP_START, 8'($urandom), 8'($urandom)});
    send_item(frame_item_t'{OP_BYTE, cfg_start ^ 8'h01, 8'($urandom)});
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding, status", m_axis_tuser, 0);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[7:0] != want.data)
          report_mismatch("data_byte", m_axis_tdata[7:0], want.data);
        if (m_axis_tdata[12:8] != want.index)
          report_mismatch("data_index", m_axis_tdata[12:8], want.index);
        if (m_axis_tdata[17:13] != want.length)
          report_mismatch("data_length", m_axis_tdata[17:13], want.length);
        if (m_axis_tdata[23:18] != 6'd0)
          report_mismatch("tdata padding", m_axis_tdata[23:18], 0);
        if (m_axis_tlast != want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // The run is abandoned once neither stream has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("checksummed_response_frame_receiver regression: fail");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_START_BYTE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BYTE;
    src_idle_pct  = 37;
    sink_idle_pct = 71;
    cfg_start     = CRFR_START_RST;
    cfg_timeout   = CRFR_TIMEOUT_RST;
    rx_cmd        = 8'd0;
    drop_frame();

    // Ignored items, re-arming, every error status but the timeout and an empty
    // frame, all with the reset register values.
    directed_rows.push_back(dir_row(OP_BYTE,   8'hFF, 8'h00));
    directed_rows.push_back(dir_row(OP_TICK,   8'h00, 8'hFF));
    directed_rows.push_back(dir_row(OP_UNUSED, 8'hFF, 8'hFF));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'h10));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_START,  8'hFF, 8'h33));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h05, 8'h00, 1'b1, ST_BAD_START));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'h33));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h01, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h34, 8'h00, 1'b1, ST_BAD_CMD));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h00, 8'h00, 1'b1, ST_BAD_LEN));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'hA5));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h1F, 8'h00, 1'b1, ST_OVERFLOW));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'h33));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h01, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h33, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'hCA, 8'h00, 1'b1, ST_EMPTY));
    directed_rows.push_back(dir_row(OP_START,  8'h00, 8'hFF));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h02, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h01, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'hFF, 8'h00));
    directed_rows.push_back(dir_row(OP_BYTE,   8'h00, 8'h00, 1'b1, ST_CHECKSUM));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].status);

    run_random_phase(8'h00, 16'd1, 37, 71);
    run_random_phase(8'hFF, 16'hFFFF, 71, 37);
    run_random_phase(8'($urandom), 16'($urandom_range(2, 6)), 0, 0);
    quiesce();

    if (results_due.size() != 0)
      report_mismatch("results never delivered", results_due.size(), 0);
    if (mismatches == 0)
      $display("checksummed_response_frame_receiver regression: pass");
    else
      $display("checksummed_response_frame_receiver regression: fail");
    $finish;
  end

endmodule
